[sv/glob_pattern_matcher_core_defines.svh]
// Assertion macros shared by the glob matcher RTL.
`ifndef GLOB_PATTERN_MATCHER_CORE_DEFINES_SVH
`define GLOB_PATTERN_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define GPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off during reset.
`define GPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gpm_pkg.sv]
// Shared constants and controller/datapath types for the glob matcher.
`default_nettype none
package gpm_pkg;

  localparam int PATTERN_DEPTH_DEF = 64;
  localparam int TEXT_DEPTH_DEF    = 256;

  // Input command codes
  localparam logic [1:0] CMD_APPEND_PAT = 2'd0;
  localparam logic [1:0] CMD_APPEND_TXT = 2'd1;
  localparam logic [1:0] CMD_MATCH      = 2'd2;

  // Pattern syntax bytes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    P_HOLD, P_INC, P_INC2, P_RESUME, P_FROM_K, P_FROM_K1
  } p_op_e;

  typedef enum logic [1:0] {
    T_HOLD, T_INC, T_RESUME
  } t_op_e;

  typedef enum logic [2:0] {
    K_HOLD, K_FROM_P1, K_INC, K_INC2, K_INC3
  } k_op_e;

  typedef enum logic [2:0] {
    PA_P, PA_P1, PA_K, PA_K1, PA_K2
  } p_addr_e;

  typedef struct packed {
    logic    append_pat;
    logic    append_txt;
    logic    clear_bufs;
    logic    match_init;
    logic    p_rd;
    p_addr_e p_addr;
    logic    t_rd;
    p_op_e   p_op;
    t_op_e   t_op;
    logic    star_set;
    k_op_e   k_op;
    logic    cls_init;
    logic    neg_set;
    logic    hit_set;
    logic    lo_load;
    logic    out_load;
    logic    out_matched;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    append_pat: 1'b0, append_txt: 1'b0, clear_bufs: 1'b0, match_init: 1'b0,
    p_rd: 1'b0, p_addr: PA_P, t_rd: 1'b0, p_op: P_HOLD, t_op: T_HOLD,
    star_set: 1'b0, k_op: K_HOLD, cls_init: 1'b0, neg_set: 1'b0,
    hit_set: 1'b0, lo_load: 1'b0, out_load: 1'b0, out_matched: 1'b0
  };

  typedef struct packed {
    logic t_lt_nt;
    logic p_lt_np;
    logic p1_lt_np;
    logic k_lt_n;
    logic k1_lt_n;
    logic k2_lt_n;
    logic have_star;
    logic ovf;
    logic out_busy;
    logic pd_star;
    logic pd_quest;
    logic pd_lbrack;
    logic pd_bslash;
    logic pd_rbrack;
    logic pd_caret;
    logic pd_dash;
    logic pd_eq_ch;
    logic lo_bslash;
    logic lo_eq_ch;
    logic range_hit;
    logic neg;
    logic hit;
  } stat_t;

endpackage
`default_nettype wire

[sv/gpm_in_if.sv]
// Input channel: command and data byte with valid/ready handshake.
`default_nettype none
interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

[sv/gpm_out_if.sv]
// Result channel: match verdict and overflow flag with valid/ready handshake.
`default_nettype none
interface gpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink (input valid, input matched, input overflow, output ready);
endinterface
`default_nettype wire

[sv/gpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[sv/gpm_datapath.sv]
// Datapath: buffers, match pointers, class registers and result register.
`default_nettype none
module gpm_datapath #(
  parameter int PATTERN_DEPTH = gpm_pkg::PATTERN_DEPTH_DEF,
  parameter int TEXT_DEPTH    = gpm_pkg::TEXT_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire gpm_pkg::ctrl_t ctrl_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output logic                out_matched_o,
  output logic                out_overflow_o,
  output gpm_pkg::stat_t      stat_o
);

  localparam int PAW = $clog2(PATTERN_DEPTH);
  localparam int PLW = $clog2(PATTERN_DEPTH + 1);
  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int TLW = $clog2(TEXT_DEPTH + 1);

  logic [PLW-1:0] plen_q, plen_d, p_q, p_d, k_q, k_d, star_at_q, star_at_d;
  logic [TLW-1:0] tlen_q, tlen_d, t_q, t_d, star_text_q, star_text_d;
  logic           ovf_q, ovf_d, have_star_q, have_star_d;
  logic           neg_q, neg_d, hit_q, hit_d;
  logic [7:0]     lo_q, lo_d;
  logic           out_valid_q, out_valid_d;
  logic           matched_q, matched_d, ovf_out_q, ovf_out_d;

  logic [PLW:0]   p1, p2, k1, k2, k3, sa1;
  logic [TLW:0]   t1, st1;
  logic           pat_full, txt_full, pat_we, txt_we;
  logic [PAW-1:0] p_raddr;
  logic [7:0]     prd, trd, mn, mx;

  // Widened pointer arithmetic
  assign p1  = {1'b0, p_q} + 1'b1;
  assign p2  = {1'b0, p_q} + 2'd2;
  assign k1  = {1'b0, k_q} + 1'b1;
  assign k2  = {1'b0, k_q} + 2'd2;
  assign k3  = {1'b0, k_q} + 2'd3;
  assign sa1 = {1'b0, star_at_q} + 1'b1;
  assign t1  = {1'b0, t_q} + 1'b1;
  assign st1 = {1'b0, star_text_q} + 1'b1;

  assign pat_full = (plen_q == PLW'(PATTERN_DEPTH));
  assign txt_full = (tlen_q == TLW'(TEXT_DEPTH));
  assign pat_we   = ctrl_i.append_pat && !pat_full;
  assign txt_we   = ctrl_i.append_txt && !txt_full;

  // Select the pattern read address
  always_comb begin
    case (ctrl_i.p_addr)
      gpm_pkg::PA_P:  p_raddr = p_q[PAW-1:0];
      gpm_pkg::PA_P1: p_raddr = p1[PAW-1:0];
      gpm_pkg::PA_K:  p_raddr = k_q[PAW-1:0];
      gpm_pkg::PA_K1: p_raddr = k1[PAW-1:0];
      gpm_pkg::PA_K2: p_raddr = k2[PAW-1:0];
      default:        p_raddr = p_q[PAW-1:0];
    endcase
  end

  gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (plen_q[PAW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (ctrl_i.p_rd),
    .raddr_i (p_raddr),
    .rdata_o (prd)
  );

  gpm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_txt_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (tlen_q[TAW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (ctrl_i.t_rd),
    .raddr_i (t_q[TAW-1:0]),
    .rdata_o (trd)
  );

  // Buffer fill and overflow
  always_comb begin
    plen_d = plen_q;
    tlen_d = tlen_q;
    ovf_d  = ovf_q;
    if (ctrl_i.append_pat) begin
      if (pat_full) ovf_d = 1'b1;
      else          plen_d = plen_q + 1'b1;
    end
    if (ctrl_i.append_txt) begin
      if (txt_full) ovf_d = 1'b1;
      else          tlen_d = tlen_q + 1'b1;
    end
    if (ctrl_i.clear_bufs) begin
      plen_d = '0;
      tlen_d = '0;
      ovf_d  = 1'b0;
    end
  end

  // Match pointers and backtrack point
  always_comb begin
    case (ctrl_i.p_op)
      gpm_pkg::P_INC:     p_d = p1[PLW-1:0];
      gpm_pkg::P_INC2:    p_d = p2[PLW-1:0];
      gpm_pkg::P_RESUME:  p_d = sa1[PLW-1:0];
      gpm_pkg::P_FROM_K:  p_d = k_q;
      gpm_pkg::P_FROM_K1: p_d = k1[PLW-1:0];
      default:            p_d = p_q;
    endcase
    case (ctrl_i.t_op)
      gpm_pkg::T_INC:    t_d = t1[TLW-1:0];
      gpm_pkg::T_RESUME: t_d = st1[TLW-1:0];
      default:           t_d = t_q;
    endcase
    star_at_d   = star_at_q;
    star_text_d = star_text_q;
    have_star_d = have_star_q;
    if (ctrl_i.star_set) begin
      star_at_d   = p_q;
      star_text_d = t_q;
      have_star_d = 1'b1;
    end
    if (ctrl_i.t_op == gpm_pkg::T_RESUME) begin
      star_text_d = st1[TLW-1:0];
    end
    if (ctrl_i.match_init) begin
      p_d         = '0;
      t_d         = '0;
      have_star_d = 1'b0;
    end
  end

  // Class walk registers
  always_comb begin
    case (ctrl_i.k_op)
      gpm_pkg::K_FROM_P1: k_d = p1[PLW-1:0];
      gpm_pkg::K_INC:     k_d = k1[PLW-1:0];
      gpm_pkg::K_INC2:    k_d = k2[PLW-1:0];
      gpm_pkg::K_INC3:    k_d = k3[PLW-1:0];
      default:            k_d = k_q;
    endcase
    neg_d = ctrl_i.cls_init ? 1'b0 : (neg_q | ctrl_i.neg_set);
    hit_d = ctrl_i.cls_init ? 1'b0 : (hit_q | ctrl_i.hit_set);
    lo_d  = ctrl_i.lo_load ? prd : lo_q;
  end

  // Result register: load on verdict, drop once taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    matched_d   = matched_q;
    ovf_out_d   = ovf_out_q;
    if (ctrl_i.out_load) begin
      out_valid_d = 1'b1;
      matched_d   = ctrl_i.out_matched;
      ovf_out_d   = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      tlen_q      <= '0;
      ovf_q       <= 1'b0;
      have_star_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      tlen_q      <= tlen_d;
      ovf_q       <= ovf_d;
      have_star_q <= have_star_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    t_q         <= t_d;
    k_q         <= k_d;
    star_at_q   <= star_at_d;
    star_text_q <= star_text_d;
    neg_q       <= neg_d;
    hit_q       <= hit_d;
    lo_q        <= lo_d;
    matched_q   <= matched_d;
    ovf_out_q   <= ovf_out_d;
  end

  // Range bounds, swapped if reversed
  assign mn = (lo_q <= prd) ? lo_q : prd;
  assign mx = (lo_q <= prd) ? prd : lo_q;

  // Status toward the controller
  always_comb begin
    stat_o.t_lt_nt   = t_q < tlen_q;
    stat_o.p_lt_np   = p_q < plen_q;
    stat_o.p1_lt_np  = p1 < {1'b0, plen_q};
    stat_o.k_lt_n    = k_q < plen_q;
    stat_o.k1_lt_n   = k1 < {1'b0, plen_q};
    stat_o.k2_lt_n   = k2 < {1'b0, plen_q};
    stat_o.have_star = have_star_q;
    stat_o.ovf       = ovf_q;
    stat_o.out_busy  = out_valid_q && !out_ready_i;
    stat_o.pd_star   = prd == gpm_pkg::CH_STAR;
    stat_o.pd_quest  = prd == gpm_pkg::CH_QUEST;
    stat_o.pd_lbrack = prd == gpm_pkg::CH_LBRACK;
    stat_o.pd_bslash = prd == gpm_pkg::CH_BSLASH;
    stat_o.pd_rbrack = prd == gpm_pkg::CH_RBRACK;
    stat_o.pd_caret  = prd == gpm_pkg::CH_CARET;
    stat_o.pd_dash   = prd == gpm_pkg::CH_DASH;
    stat_o.pd_eq_ch  = prd == trd;
    stat_o.lo_bslash = lo_q == gpm_pkg::CH_BSLASH;
    stat_o.lo_eq_ch  = lo_q == trd;
    stat_o.range_hit = (trd >= mn) && (trd <= mx);
    stat_o.neg       = neg_q;
    stat_o.hit       = hit_q;
  end

  assign out_valid_o    = out_valid_q;
  assign out_matched_o  = matched_q;
  assign out_overflow_o = ovf_out_q;

endmodule
`default_nettype wire

[sv/gpm_controller.sv]
// Controller: one-hot sequencer for appends and the backtracking match.
`default_nettype none
module gpm_controller (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_command_i,
  output logic                in_ready_o,
  input  wire gpm_pkg::stat_t stat_i,
  output gpm_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_LOOP     = 11'b000_0000_0010,
    S_DEC      = 11'b000_0000_0100,
    S_ESC      = 11'b000_0000_1000,
    S_CLS_HEAD = 11'b000_0001_0000,
    S_CLS_RD   = 11'b000_0010_0000,
    S_CLS_E0   = 11'b000_0100_0000,
    S_CLS_E1   = 11'b000_1000_0000,
    S_CLS_E2   = 11'b001_0000_0000,
    S_TAIL     = 11'b010_0000_0000,
    S_TAIL_D   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fail, finish, fin_match, cls_end, cls_ok;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
  assign cls_ok     = stat_i.neg ^ stat_i.hit;

  always_comb begin
    ctrl_o    = gpm_pkg::CTRL_NOP;
    state_d   = state_q;
    fail      = 1'b0;
    finish    = 1'b0;
    fin_match = 1'b0;
    cls_end   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          case (in_command_i)
            gpm_pkg::CMD_APPEND_PAT: ctrl_o.append_pat = 1'b1;
            gpm_pkg::CMD_APPEND_TXT: ctrl_o.append_txt = 1'b1;
            gpm_pkg::CMD_MATCH: begin
              if (stat_i.ovf) begin
                finish = 1'b1;
              end else begin
                ctrl_o.match_init = 1'b1;
                state_d           = S_LOOP;
              end
            end
            default: ;
          endcase
        end
      end
      // Fetch the next pattern and text bytes, or finish the text
      S_LOOP: begin
        if (stat_i.t_lt_nt) begin
          ctrl_o.p_rd   = 1'b1;
          ctrl_o.p_addr = gpm_pkg::PA_P;
          ctrl_o.t_rd   = 1'b1;
          state_d       = S_DEC;
        end else begin
          state_d = S_TAIL;
        end
      end
      // Decode one pattern element against the text byte
      S_DEC: begin
        state_d = S_LOOP;
        if (!stat_i.p_lt_np) begin
          fail = 1'b1;
        end else if (stat_i.pd_star) begin
          ctrl_o.star_set = 1'b1;
          ctrl_o.p_op     = gpm_pkg::P_INC;
        end else if (stat_i.pd_quest) begin
          ctrl_o.p_op = gpm_pkg::P_INC;
          ctrl_o.t_op = gpm_pkg::T_INC;
        end else if (stat_i.pd_lbrack) begin
          if (stat_i.p1_lt_np) begin
            ctrl_o.k_op     = gpm_pkg::K_FROM_P1;
            ctrl_o.cls_init = 1'b1;
            ctrl_o.p_rd     = 1'b1;
            ctrl_o.p_addr   = gpm_pkg::PA_P1;
            state_d         = S_CLS_HEAD;
          end else begin
            fail = 1'b1;
          end
        end else if (stat_i.pd_bslash && stat_i.p1_lt_np) begin
          ctrl_o.p_rd   = 1'b1;
          ctrl_o.p_addr = gpm_pkg::PA_P1;
          state_d       = S_ESC;
        end else if (stat_i.pd_eq_ch) begin
          ctrl_o.p_op = gpm_pkg::P_INC;
          ctrl_o.t_op = gpm_pkg::T_INC;
        end else begin
          fail = 1'b1;
        end
      end
      // Escaped literal outside a class
      S_ESC: begin
        state_d = S_LOOP;
        if (stat_i.pd_eq_ch) begin
          ctrl_o.p_op = gpm_pkg::P_INC2;
          ctrl_o.t_op = gpm_pkg::T_INC;
        end else begin
          fail = 1'b1;
        end
      end
      // Optional negation mark
      S_CLS_HEAD: begin
        if (stat_i.pd_caret) begin
          ctrl_o.neg_set = 1'b1;
          ctrl_o.k_op    = gpm_pkg::K_INC;
        end
        state_d = S_CLS_RD;
      end
      S_CLS_RD: begin
        if (stat_i.k_lt_n) begin
          ctrl_o.p_rd   = 1'b1;
          ctrl_o.p_addr = gpm_pkg::PA_K;
          state_d       = S_CLS_E0;
        end else begin
          cls_end     = 1'b1;
          ctrl_o.p_op = gpm_pkg::P_FROM_K;
        end
      end
      // First byte of a class member
      S_CLS_E0: begin
        if (stat_i.pd_rbrack) begin
          cls_end     = 1'b1;
          ctrl_o.p_op = gpm_pkg::P_FROM_K1;
        end else begin
          ctrl_o.lo_load = 1'b1;
          if (stat_i.k1_lt_n) begin
            ctrl_o.p_rd   = 1'b1;
            ctrl_o.p_addr = gpm_pkg::PA_K1;
            state_d       = S_CLS_E1;
          end else begin
            ctrl_o.hit_set = stat_i.pd_eq_ch;
            ctrl_o.k_op    = gpm_pkg::K_INC;
            state_d        = S_CLS_RD;
          end
        end
      end
      // Escape, range start or plain member
      S_CLS_E1: begin
        state_d = S_CLS_RD;
        if (stat_i.lo_bslash) begin
          ctrl_o.hit_set = stat_i.pd_eq_ch;
          ctrl_o.k_op    = gpm_pkg::K_INC2;
        end else if (stat_i.pd_dash && stat_i.k2_lt_n) begin
          ctrl_o.p_rd   = 1'b1;
          ctrl_o.p_addr = gpm_pkg::PA_K2;
          state_d       = S_CLS_E2;
        end else begin
          ctrl_o.hit_set = stat_i.lo_eq_ch;
          ctrl_o.k_op    = gpm_pkg::K_INC;
        end
      end
      // Range end, unless it closes the class
      S_CLS_E2: begin
        state_d = S_CLS_RD;
        if (!stat_i.pd_rbrack) begin
          ctrl_o.hit_set = stat_i.range_hit;
          ctrl_o.k_op    = gpm_pkg::K_INC3;
        end else begin
          ctrl_o.hit_set = stat_i.lo_eq_ch;
          ctrl_o.k_op    = gpm_pkg::K_INC;
        end
      end
      // Skip trailing stars after the text is consumed
      S_TAIL: begin
        if (stat_i.p_lt_np) begin
          ctrl_o.p_rd   = 1'b1;
          ctrl_o.p_addr = gpm_pkg::PA_P;
          state_d       = S_TAIL_D;
        end else begin
          finish    = 1'b1;
          fin_match = 1'b1;
        end
      end
      S_TAIL_D: begin
        if (stat_i.pd_star) begin
          ctrl_o.p_op = gpm_pkg::P_INC;
          state_d     = S_TAIL;
        end else begin
          finish = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Close a class: advance text on a hit, else mismatch
    if (cls_end) begin
      state_d = S_LOOP;
      if (cls_ok) ctrl_o.t_op = gpm_pkg::T_INC;
      else        fail = 1'b1;
    end

    // Backtrack to the last star, or give up
    if (fail) begin
      if (stat_i.have_star) begin
        ctrl_o.p_op = gpm_pkg::P_RESUME;
        ctrl_o.t_op = gpm_pkg::T_RESUME;
        state_d     = S_LOOP;
      end else begin
        finish = 1'b1;
      end
    end

    // Emit the verdict and clear the buffers
    if (finish) begin
      ctrl_o.out_load    = 1'b1;
      ctrl_o.out_matched = fin_match;
      ctrl_o.clear_bufs  = 1'b1;
      state_d            = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/glob_pattern_matcher_core.sv]
// Glob matcher top level: channel plumbing, controller, datapath, checks.
//
// Usage: send transactions on in_i. Command append-pattern and append-text
// store data_byte into a 64-byte pattern buffer and a 256-byte text buffer
// (sizes set by parameters); appends are taken one per cycle, back to back, while no result is stalled.
// A full buffer drops the byte and flags overflow. Command match runs a
// greedy wildcard match ('*', '?', bracket classes, backslash escapes) and
// sends one transaction on out_o with matched and overflow; both buffers and
// the flag are then cleared. Unused command 3 is dropped.
// A match walks the pattern element by element, with extra states for an
// escape, for opening, walking and closing a class, and for each trailing
// star; each backtrack to the last star restarts that walk, so match time
// grows with pattern times text length. The pattern memory's single
// registered read port paces the walk.
// The result is valid the cycle after the verdict; with overflow pending the
// result is loaded in the accept cycle.
// Reset clears lengths, flag, sequencer and result valid; no memory sweep.
// A stalled result is held in the output register, and no new transaction,
// append or match, is taken until the result is taken.
`default_nettype none
`include "glob_pattern_matcher_core_defines.svh"
module glob_pattern_matcher_core #(
  parameter int PATTERN_DEPTH = gpm_pkg::PATTERN_DEPTH_DEF,
  parameter int TEXT_DEPTH    = gpm_pkg::TEXT_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gpm_in_if.sink     in_i,
  gpm_out_if.source  out_o
);

  gpm_pkg::ctrl_t ctrl;
  gpm_pkg::stat_t stat;

  gpm_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  gpm_datapath #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .TEXT_DEPTH    (TEXT_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .data_byte_i    (in_i.data_byte),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_matched_o  (out_o.matched),
    .out_overflow_o (out_o.overflow),
    .stat_o         (stat)
  );

  // Checks
  `GPM_ASSERT_IMP(a_ready_needs_free_out, in_i.ready, !out_o.valid || out_o.ready, "input taken while result stalled")
  `GPM_ASSERT_IMP(a_no_match_on_overflow, out_o.valid && out_o.matched, !out_o.overflow, "match reported with overflow")
  `GPM_ASSERT_NXT(a_append_no_result, in_i.valid && in_i.ready && in_i.command == gpm_pkg::CMD_APPEND_PAT, !$rose(out_o.valid), "append produced a result")

endmodule
`default_nettype wire

[sim/tb_glob_pattern_matcher_core.sv]
// Self-checking testbench for the glob matcher core: directed table, random cases.
`default_nettype none
module tb_glob_pattern_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PAT_DEPTH = gpm_pkg::PATTERN_DEPTH_DEF;
  localparam int TXT_DEPTH = gpm_pkg::TEXT_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 440;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct {
    string pattern;
    string text;
    bit    known;
    bit    want;
  } glob_case_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gpm_in_if  in_if ();
  gpm_out_if out_if ();

  glob_pattern_matcher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the buffers
  logic [7:0] pat_mem [PAT_DEPTH];
  logic [7:0] txt_mem [TXT_DEPTH];
  int         pat_cnt;
  int         txt_cnt;
  bit         ovf_seen;

  verdict_t   verdict_q [$];
  int         errors;
  int         verdicts_seen;
  int         items_sent;
  int         ovf_verdicts;
  bit         quiet;
  bit         hold_off_req;
  longint     cycles;

  // Bracket class test; p starts at '[' and ends past ']' or at the end
  function automatic bit class_hit(inout int p, input logic [7:0] ch);
    int k;
    bit neg;
    bit hit;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] tmp;
    k = p + 1;
    neg = 1'b0;
    hit = 1'b0;
    if (k < pat_cnt && pat_mem[k] == gpm_pkg::CH_CARET) begin
      neg = 1'b1;
      k++;
    end
    while (k < pat_cnt && pat_mem[k] != gpm_pkg::CH_RBRACK) begin
      if (pat_mem[k] == gpm_pkg::CH_BSLASH && k + 1 < pat_cnt) begin
        if (pat_mem[k+1] == ch) hit = 1'b1;
        k += 2;
      end else if (k + 2 < pat_cnt && pat_mem[k+1] == gpm_pkg::CH_DASH &&
                   pat_mem[k+2] != gpm_pkg::CH_RBRACK) begin
        lo = pat_mem[k];
        hi = pat_mem[k+2];
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
        if (ch >= lo && ch <= hi) hit = 1'b1;
        k += 3;
      end else begin
        if (pat_mem[k] == ch) hit = 1'b1;
        k++;
      end
    end
    p = (k < pat_cnt) ? k + 1 : k;
    return neg ? !hit : hit;
  endfunction

  // Greedy match with backtrack to the most recent star
  function automatic bit glob_matches();
    int p;
    int t;
    int star_p;
    int star_t;
    bit have_star;
    bit miss;
    p = 0;
    t = 0;
    star_p = 0;
    star_t = 0;
    have_star = 1'b0;
    while (t < txt_cnt) begin
      miss = 1'b0;
      if (p < pat_cnt && pat_mem[p] == gpm_pkg::CH_STAR) begin
        have_star = 1'b1;
        star_p = p;
        p++;
        star_t = t;
      end else if (p < pat_cnt && pat_mem[p] == gpm_pkg::CH_QUEST) begin
        p++;
        t++;
      end else if (p < pat_cnt && pat_mem[p] == gpm_pkg::CH_LBRACK) begin
        if (class_hit(p, txt_mem[t])) t++;
        else miss = 1'b1;
      end else if (p < pat_cnt && pat_mem[p] == gpm_pkg::CH_BSLASH &&
                   p + 1 < pat_cnt) begin
        if (pat_mem[p+1] == txt_mem[t]) begin
          p += 2;
          t++;
        end else miss = 1'b1;
      end else if (p < pat_cnt && pat_mem[p] == txt_mem[t]) begin
        p++;
        t++;
      end else begin
        miss = 1'b1;
      end
      if (miss) begin
        if (!have_star) return 1'b0;
        p = star_p + 1;
        star_t++;
        t = star_t;
      end
    end
    while (p < pat_cnt && pat_mem[p] == gpm_pkg::CH_STAR) p++;
    return p == pat_cnt;
  endfunction

  // Advance the shadow state by one accepted transaction
  function automatic void absorb(logic [1:0] cmd, logic [7:0] data);
    verdict_t v;
    case (cmd)
      gpm_pkg::CMD_APPEND_PAT: begin
        if (pat_cnt < PAT_DEPTH) pat_mem[pat_cnt++] = data;
        else ovf_seen = 1'b1;
      end
      gpm_pkg::CMD_APPEND_TXT: begin
        if (txt_cnt < TXT_DEPTH) txt_mem[txt_cnt++] = data;
        else ovf_seen = 1'b1;
      end
      gpm_pkg::CMD_MATCH: begin
        v.matched = ovf_seen ? 1'b0 : glob_matches();
        v.overflow = ovf_seen;
        verdict_q = {verdict_q, v};
        pat_cnt = 0;
        txt_cnt = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Offer one transaction, idle at random first, hold until accepted
  task automatic send(logic [1:0] cmd, logic [7:0] data);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.data_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
    absorb(cmd, data);
    items_sent++;
  endtask

  task automatic send_string(logic [1:0] cmd, string s);
    for (int i = 0; i < s.len(); i++) send(cmd, s[i]);
  endtask

  function automatic logic [7:0] pick_pat_byte();
    logic [7:0] syms [10] = '{"a", "b", "a", gpm_pkg::CH_STAR, gpm_pkg::CH_QUEST,
                              gpm_pkg::CH_LBRACK, gpm_pkg::CH_RBRACK,
                              gpm_pkg::CH_CARET, gpm_pkg::CH_DASH,
                              gpm_pkg::CH_BSLASH};
    if ($urandom_range(0, 9) == 0) return 8'($urandom());
    return syms[$urandom_range(0, 9)];
  endfunction

  function automatic logic [7:0] pick_txt_byte();
    logic [7:0] syms [7] = '{"a", "b", "a", "b", gpm_pkg::CH_DASH,
                             gpm_pkg::CH_RBRACK, gpm_pkg::CH_BSLASH};
    if ($urandom_range(0, 7) == 0) return 8'($urandom());
    return syms[$urandom_range(0, 6)];
  endfunction

  // Random case: mostly short buffers, now and then one that runs over
  task automatic random_case();
    int np;
    int nt;
    int ip;
    int it;
    np = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
    nt = ($urandom_range(0, 30) == 0) ? $urandom_range(250, 260) : $urandom_range(0, 12);
    ip = 0;
    it = 0;
    while (ip < np || it < nt) begin
      if ($urandom_range(0, 40) == 0) send(CMD_UNUSED, 8'($urandom()));
      if (it >= nt || (ip < np && $urandom_range(0, 1) == 0)) begin
        send(gpm_pkg::CMD_APPEND_PAT, pick_pat_byte());
        ip++;
      end else begin
        send(gpm_pkg::CMD_APPEND_TXT, pick_txt_byte());
        it++;
      end
    end
    send(gpm_pkg::CMD_MATCH, 8'($urandom()));
  endtask

  // Result receiver: random stalls plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      verdicts_seen++;
      if (out_if.overflow) ovf_verdicts++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: matched=%0b overflow=%0b",
                 $time, out_if.matched, out_if.overflow);
      end else begin
        want = verdict_q.pop_front();
        if (out_if.matched !== want.matched) begin
          errors++;
          $display("%0t: matched expected %0b actual %0b", $time, want.matched,
                   out_if.matched);
        end
        if (out_if.overflow !== want.overflow) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                   out_if.overflow);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, verdict_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  glob_case_t directed [] = '{
    '{"", "", 1'b1, 1'b1},
    '{"*", "", 1'b1, 1'b1},
    '{"?", "", 1'b1, 1'b0},
    '{"a*b?", "axxbz", 1'b0, 1'b0},
    '{"[^a-]", "]", 1'b0, 1'b0},
    '{"[z-a]", "m", 1'b0, 1'b0},
    '{"\\*", "*", 1'b0, 1'b0},
    '{"a\\", "a\\", 1'b0, 1'b0},
    '{"[ab", "b", 1'b0, 1'b0},
    '{"[a-]", "-", 1'b0, 1'b0},
    '{"[\\", "\\", 1'b0, 1'b0}
  };

  initial begin
    verdict_t last;
    int start_items;
    pat_cnt = 0;
    txt_cnt = 0;
    ovf_seen = 1'b0;
    errors = 0;
    verdicts_seen = 0;
    ovf_verdicts = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    cycles = 0;
    in_if.valid = 1'b0;
    in_if.command = gpm_pkg::CMD_APPEND_PAT;
    in_if.data_byte = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; an unused command and extreme bytes ride along
    send(CMD_UNUSED, 8'hFF);
    foreach (directed[i]) begin
      send_string(gpm_pkg::CMD_APPEND_PAT, directed[i].pattern);
      send_string(gpm_pkg::CMD_APPEND_TXT, directed[i].text);
      send(gpm_pkg::CMD_MATCH, (i % 2) ? 8'hFF : 8'h00);
      last = verdict_q[$];
      if (directed[i].known && last.matched !== directed[i].want) begin
        errors++;
        $display("%0t: table row %0d expected %0b, prediction %0b", $time, i,
                 directed[i].want, last.matched);
      end
    end

    // Random cases; the first ones run into a long result stall
    hold_off_req = 1'b1;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (items_sent - start_items > RANDOM_ITEMS - 60) quiet = 1'b1;
      random_case();
    end
    in_if.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d match results (%0d with overflow).",
             items_sent, verdicts_seen, ovf_verdicts);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/gpm_pkg.sv
sv/gpm_in_if.sv
sv/gpm_out_if.sv
sv/gpm_ram.sv
sv/gpm_datapath.sv
sv/gpm_controller.sv
sv/glob_pattern_matcher_core.sv
sim/tb_glob_pattern_matcher_core.sv
